### hw/rtl/fps_pkg.sv
// Shared types, constants and helpers for the frame pacing scheduler.
`default_nettype none
package fps_pkg;

    localparam int TIME_W   = 63;
    localparam int PERIOD_W = 32;
    localparam int COUNT_W  = 48;
    localparam int EPOCH_W  = 16;
    localparam int ACCUM_W  = 33;
    localparam int LATE_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // The multiplier takes a 16-bit digit of its 48-bit operand per step.
    localparam int MUL_DIGIT_W = 16;
    localparam int MUL_STEPS   = COUNT_W / MUL_DIGIT_W;
    localparam int MUL_ACC_W   = PERIOD_W + COUNT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);

    // The divider produces one quotient bit per step.
    localparam int DIV_STEPS = PERIOD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [TIME_W-1:0]   T63_MAX   = {TIME_W{1'b1}};
    localparam logic [PERIOD_W-1:0] SKIP_MAX  = {PERIOD_W{1'b1}};

    localparam logic [LATE_W-1:0]     LATENESS_RESET = 8'd1;
    localparam logic [CFG_DATA_W-1:0] OVERLOAD_RESET = 32'd705600000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LATENESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLOAD = 1'b1;

    // Result status codes.
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_BUSY     = 2'd1;
    localparam logic [1:0] STS_IDLE_FIN = 2'd2;
    localparam logic [1:0] STS_ZERO_PER = 2'd3;

    typedef struct packed {
        logic                go;
        logic [PERIOD_W-1:0] mcand;
        logic [COUNT_W-1:0]  mplier;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] product;
    } t_mul_rsp;

    typedef struct packed {
        logic                go;
        logic [TIME_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [PERIOD_W-1:0] quotient;
    } t_div_rsp;

    // Time sum that saturates at the largest time value.
    function automatic logic [TIME_W-1:0] sat_add63(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? T63_MAX : s[TIME_W-1:0];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/frame_pacing_scheduler.sv
// Frame pacing scheduler top level: sequencer, timeline state and result registers.
//
//   Channel   Signals                                   Direction
//   request   i_valid / o_ready, i_action..period       in
//   result    o_valid / i_ready, o_status..total        out
//   config    i_cfg_we, i_cfg_idx, i_cfg_data           in, write only
//
// One request at a time: o_ready is high only while the sequencer is idle.
// The long finish case is the 32-step divider that counts skipped frames, and
// every multiply is 3 steps of the shared 32x16 multiplier.
// Reset is synchronous and active low; it restores the register defaults.
// A result is held until i_ready takes it, and no new request is taken meanwhile.
`default_nettype none
module frame_pacing_scheduler (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output wire logic                              o_ready,
    input  wire logic                              i_action,
    input  wire logic [fps_pkg::TIME_W-1:0]        i_now,
    input  wire logic [fps_pkg::PERIOD_W-1:0]      i_frame_period,
    output wire logic                              o_valid,
    input  wire logic                              i_ready,
    output wire logic [1:0]                        o_status,
    output wire logic [fps_pkg::COUNT_W-1:0]       o_frame_number,
    output wire logic [fps_pkg::EPOCH_W-1:0]       o_epoch,
    output wire logic [fps_pkg::TIME_W-1:0]        o_pts,
    output wire logic [fps_pkg::TIME_W-1:0]        o_target_or_wake,
    output wire logic                              o_discontinuity,
    output wire logic [fps_pkg::TIME_W-1:0]        o_render_duration,
    output wire logic [fps_pkg::TIME_W-1:0]        o_start_lateness,
    output wire logic signed [fps_pkg::TIME_W:0]   o_deadline_margin,
    output wire logic                              o_sustained_overload,
    output wire logic [fps_pkg::PERIOD_W-1:0]      o_skipped_frames,
    output wire logic [fps_pkg::COUNT_W-1:0]       o_skipped_total,
    input  wire logic                              i_cfg_we,
    input  wire logic [fps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [fps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import fps_pkg::*;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_CHECK      = 4'd1;
    localparam logic [3:0] S_B_GO       = 4'd2;
    localparam logic [3:0] S_B_WAIT     = 4'd3;
    localparam logic [3:0] S_F_DL       = 4'd4;
    localparam logic [3:0] S_F_NT_WAIT  = 4'd5;
    localparam logic [3:0] S_F_PM_GO    = 4'd6;
    localparam logic [3:0] S_F_PM_WAIT  = 4'd7;
    localparam logic [3:0] S_F_LIM      = 4'd8;
    localparam logic [3:0] S_F_SAT      = 4'd9;
    localparam logic [3:0] S_F_DIV_WAIT = 4'd10;
    localparam logic [3:0] S_F_UPD      = 4'd11;
    localparam logic [3:0] S_F_WK_GO    = 4'd12;
    localparam logic [3:0] S_F_WK_WAIT  = 4'd13;
    localparam logic [3:0] S_OUT        = 4'd14;

    logic [3:0]            r_state;
    logic [3:0]            n_state;

    // Configuration.
    logic [LATE_W-1:0]     r_lateness;
    logic [CFG_DATA_W-1:0] r_limit;

    // Latched request.
    logic                  r_act;
    logic [TIME_W-1:0]     r_now;
    logic [PERIOD_W-1:0]   r_per;

    // Timeline state.
    logic                  r_frame_active;
    logic                  r_timeline_ready;
    logic [PERIOD_W-1:0]   r_period_store;
    logic [TIME_W-1:0]     r_anchor_time;
    logic [COUNT_W-1:0]    r_timeline_index;
    logic [ACCUM_W-1:0]    r_overload_accum;
    logic [COUNT_W-1:0]    r_next_number;
    logic [EPOCH_W-1:0]    r_epoch_count;
    logic [COUNT_W-1:0]    r_skip_total;
    logic [TIME_W-1:0]     r_start_time;
    logic [TIME_W-1:0]     r_target_time;
    logic [TIME_W-1:0]     r_tmp;

    // Result registers.
    logic [1:0]            r_o_status;
    logic [COUNT_W-1:0]    r_o_frame_number;
    logic [EPOCH_W-1:0]    r_o_epoch;
    logic [TIME_W-1:0]     r_o_pts;
    logic [TIME_W-1:0]     r_o_target_or_wake;
    logic                  r_o_discontinuity;
    logic [TIME_W-1:0]     r_o_render;
    logic [TIME_W-1:0]     r_o_lateness;
    logic [TIME_W:0]       r_o_margin;
    logic                  r_o_overload;
    logic [PERIOD_W-1:0]   r_o_skip;
    logic [COUNT_W-1:0]    r_o_skip_total;

    t_mul_req              w_mul_req;
    t_mul_rsp              w_mul_rsp;
    t_div_req              w_div_req;
    t_div_rsp              w_div_rsp;

    logic                  w_begin_err;
    logic                  w_reanchor;
    logic [ACCUM_W-1:0]    w_accum_sum;
    logic [ACCUM_W-1:0]    w_accum_new;
    logic [COUNT_W-1:0]    w_skip_ext;

    assign w_begin_err = r_frame_active ||
                         ((!r_timeline_ready || (r_per != r_period_store)) && (r_per == '0));
    assign w_reanchor  = !r_timeline_ready || (r_per != r_period_store);
    assign w_skip_ext  = COUNT_W'(r_o_skip);

    // The accumulator never exceeds a 32-bit limit, so the sum cannot overflow.
    assign w_accum_sum = r_overload_accum + ACCUM_W'(r_period_store);
    always_comb begin
        if (r_now > r_tmp) begin
            w_accum_new = (w_accum_sum > ACCUM_W'(r_limit)) ? ACCUM_W'(r_limit) : w_accum_sum;
        end else begin
            w_accum_new = '0;
        end
    end

    // Shared multiplier operands.
    always_comb begin
        w_mul_req.mcand = r_period_store;
        w_mul_req.go    = (r_state == S_B_GO) || (r_state == S_F_DL) ||
                          (r_state == S_F_PM_GO) || (r_state == S_F_WK_GO);
        unique case (r_state)
            S_F_DL:    w_mul_req.mplier = r_timeline_index + COUNT_W'(1);
            S_F_PM_GO: w_mul_req.mplier = COUNT_W'(r_lateness);
            default:   w_mul_req.mplier = r_timeline_index;
        endcase
    end

    assign w_div_req.go       = (r_state == S_F_SAT) &&
                                (PERIOD_W'(r_tmp[TIME_W-1:PERIOD_W]) < r_period_store);
    assign w_div_req.dividend = r_tmp;
    assign w_div_req.divisor  = r_period_store;

    fps_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    fps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:       if (i_valid) n_state = S_CHECK;
            S_CHECK: begin
                if (!r_act) begin
                    n_state = w_begin_err ? S_OUT : S_B_GO;
                end else begin
                    n_state = r_frame_active ? S_F_DL : S_OUT;
                end
            end
            S_B_GO:       n_state = S_B_WAIT;
            S_B_WAIT:     if (w_mul_rsp.done) n_state = S_OUT;
            S_F_DL:       n_state = S_F_NT_WAIT;
            S_F_NT_WAIT:  if (w_mul_rsp.done) n_state = S_F_PM_GO;
            S_F_PM_GO:    n_state = S_F_PM_WAIT;
            S_F_PM_WAIT:  if (w_mul_rsp.done) n_state = S_F_LIM;
            S_F_LIM:      n_state = (r_now > r_tmp) ? S_F_SAT : S_F_UPD;
            S_F_SAT:      n_state = w_div_req.go ? S_F_DIV_WAIT : S_F_UPD;
            S_F_DIV_WAIT: if (w_div_rsp.done) n_state = S_F_UPD;
            S_F_UPD:      n_state = S_F_WK_GO;
            S_F_WK_GO:    n_state = S_F_WK_WAIT;
            S_F_WK_WAIT:  if (w_mul_rsp.done) n_state = S_OUT;
            S_OUT:        if (i_ready) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_lateness       <= LATENESS_RESET;
            r_limit          <= OVERLOAD_RESET;
            r_frame_active   <= 1'b0;
            r_timeline_ready <= 1'b0;
            r_period_store   <= '0;
            r_anchor_time    <= '0;
            r_timeline_index <= '0;
            r_overload_accum <= '0;
            r_next_number    <= '0;
            r_epoch_count    <= '0;
            r_skip_total     <= '0;
            r_start_time     <= '0;
            r_target_time    <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LATENESS: r_lateness <= i_cfg_data[LATE_W-1:0];
                    CFG_OVERLOAD: r_limit    <= i_cfg_data;
                    default:      r_limit    <= r_limit;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_act              <= i_action;
                        r_now              <= i_now;
                        r_per              <= i_frame_period;
                        r_o_status         <= STS_OK;
                        r_o_frame_number   <= '0;
                        r_o_epoch          <= '0;
                        r_o_pts            <= '0;
                        r_o_target_or_wake <= '0;
                        r_o_discontinuity  <= 1'b0;
                        r_o_render         <= '0;
                        r_o_lateness       <= '0;
                        r_o_margin         <= '0;
                        r_o_overload       <= 1'b0;
                        r_o_skip           <= '0;
                        r_o_skip_total     <= '0;
                    end
                end
                S_CHECK: begin
                    if (!r_act) begin
                        if (r_frame_active) begin
                            r_o_status <= STS_BUSY;
                        end else if (w_reanchor) begin
                            if (r_per == '0) begin
                                r_o_status <= STS_ZERO_PER;
                            end else begin
                                r_period_store    <= r_per;
                                r_anchor_time     <= r_now;
                                r_timeline_index  <= '0;
                                r_overload_accum  <= '0;
                                r_timeline_ready  <= 1'b1;
                                r_epoch_count     <= r_epoch_count + 1'b1;
                                r_o_discontinuity <= 1'b1;
                            end
                        end
                    end else if (!r_frame_active) begin
                        r_o_status <= STS_IDLE_FIN;
                    end else begin
                        // r_tmp holds the deadline for the next step.
                        r_tmp        <= sat_add63(r_target_time, TIME_W'(r_period_store));
                        r_o_render   <= (r_now > r_start_time) ? r_now - r_start_time : '0;
                        r_o_lateness <= (r_start_time > r_target_time) ?
                                        r_start_time - r_target_time : '0;
                    end
                end
                S_B_WAIT: begin
                    if (w_mul_rsp.done) begin
                        r_target_time      <= sat_add63(r_anchor_time, w_mul_rsp.product);
                        r_o_target_or_wake <= sat_add63(r_anchor_time, w_mul_rsp.product);
                        r_o_pts            <= w_mul_rsp.product;
                        r_start_time       <= r_now;
                        r_frame_active     <= 1'b1;
                        r_o_frame_number   <= r_next_number;
                        r_o_epoch          <= r_epoch_count;
                    end
                end
                S_F_DL: begin
                    r_o_margin       <= {1'b0, r_tmp} - {1'b0, r_now};
                    r_overload_accum <= w_accum_new;
                    r_o_overload     <= (w_accum_new >= ACCUM_W'(r_limit));
                end
                S_F_NT_WAIT: begin
                    if (w_mul_rsp.done) r_tmp <= sat_add63(r_anchor_time, w_mul_rsp.product);
                end
                S_F_PM_WAIT: begin
                    if (w_mul_rsp.done) r_tmp <= sat_add63(r_tmp, w_mul_rsp.product);
                end
                S_F_LIM: begin
                    // Past the lateness limit: keep the excess minus one for the divide.
                    if (r_now > r_tmp) r_tmp <= r_now - r_tmp - TIME_W'(1);
                end
                S_F_SAT: begin
                    if (!w_div_req.go) r_o_skip <= SKIP_MAX;
                end
                S_F_DIV_WAIT: begin
                    if (w_div_rsp.done) begin
                        r_o_skip <= (w_div_rsp.quotient == SKIP_MAX) ?
                                    SKIP_MAX : w_div_rsp.quotient + 1'b1;
                    end
                end
                S_F_UPD: begin
                    r_skip_total     <= r_skip_total + w_skip_ext;
                    r_o_skip_total   <= r_skip_total + w_skip_ext;
                    r_timeline_index <= r_timeline_index + COUNT_W'(1) + w_skip_ext;
                    r_next_number    <= r_next_number + COUNT_W'(1) + w_skip_ext;
                    r_o_frame_number <= r_next_number;
                    r_o_epoch        <= r_epoch_count;
                    r_frame_active   <= 1'b0;
                end
                S_F_WK_WAIT: begin
                    if (w_mul_rsp.done) begin
                        r_o_target_or_wake <= sat_add63(r_anchor_time, w_mul_rsp.product);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ready              = (r_state == S_IDLE);
    assign o_valid              = (r_state == S_OUT);
    assign o_status             = r_o_status;
    assign o_frame_number       = r_o_frame_number;
    assign o_epoch              = r_o_epoch;
    assign o_pts                = r_o_pts;
    assign o_target_or_wake     = r_o_target_or_wake;
    assign o_discontinuity      = r_o_discontinuity;
    assign o_render_duration    = r_o_render;
    assign o_start_lateness     = r_o_lateness;
    assign o_deadline_margin    = r_o_margin;
    assign o_sustained_overload = r_o_overload;
    assign o_skipped_frames     = r_o_skip;
    assign o_skipped_total      = r_o_skip_total;

    // An open frame always has a valid period behind it.
    a_active_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_active |-> (r_period_store != '0))
        else $error("frame active with zero stored period");

    // The accumulator saturates at a 32-bit limit, so its top bit stays clear.
    a_accum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_active |-> !r_overload_accum[ACCUM_W-1])
        else $error("overload accumulator exceeded 32 bits");

    a_mul_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> (r_state == S_B_WAIT || r_state == S_F_NT_WAIT ||
                            r_state == S_F_PM_WAIT || r_state == S_F_WK_WAIT))
        else $error("multiplier finished outside a wait state");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_F_DIV_WAIT))
        else $error("divider finished outside its wait state");

    // A request that ends in an error leaves the timeline untouched.
    a_error_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && n_state == S_OUT) |=>
            ($stable(r_frame_active) && $stable(r_timeline_index) &&
             $stable(r_epoch_count)))
        else $error("error result changed timeline state");

endmodule
`default_nettype wire

### hw/rtl/fps_mul.sv
// Iterative saturating multiplier: 32-bit period times 48-bit count, 16 bits a step.
`default_nettype none
module fps_mul (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  fps_pkg::t_mul_req     i_req,
    output fps_pkg::t_mul_rsp     o_rsp
);
    import fps_pkg::*;

    logic [PERIOD_W-1:0]              r_a;
    logic [COUNT_W-1:0]               r_b;
    logic [MUL_ACC_W-1:0]             r_acc;
    logic [MUL_CNT_W-1:0]             r_cnt;
    logic                             r_busy;
    logic                             r_done;
    logic [PERIOD_W+MUL_DIGIT_W-1:0]  w_pp;

    assign w_pp = (PERIOD_W+MUL_DIGIT_W)'(r_a) *
                  (PERIOD_W+MUL_DIGIT_W)'(r_b[COUNT_W-1 -: MUL_DIGIT_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_a    <= i_req.mcand;
                r_b    <= i_req.mplier;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // Most significant digit first: shift the partial sum, add the new product.
                r_acc <= {r_acc[MUL_ACC_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}} +
                         MUL_ACC_W'(w_pp);
                r_b   <= {r_b[COUNT_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = (|r_acc[MUL_ACC_W-1:TIME_W]) ? T63_MAX : r_acc[TIME_W-1:0];

endmodule
`default_nettype wire

### hw/rtl/fps_div.sv
// Restoring divider, one quotient bit a step, for a quotient known to fit 32 bits.
`default_nettype none
module fps_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  fps_pkg::t_div_req     i_req,
    output fps_pkg::t_div_rsp     o_rsp
);
    import fps_pkg::*;

    logic [PERIOD_W-1:0]  r_d;
    logic [PERIOD_W-1:0]  r_x;
    logic [PERIOD_W-1:0]  r_rem;
    logic [PERIOD_W-1:0]  r_q;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [PERIOD_W:0]    w_trial;
    logic [PERIOD_W:0]    w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, r_x[PERIOD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_ge    = (w_trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                // The caller guarantees the upper dividend bits are below the divisor.
                r_rem  <= {1'b0, i_req.dividend[TIME_W-1:PERIOD_W]};
                r_x    <= i_req.dividend[PERIOD_W-1:0];
                r_d    <= i_req.divisor;
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[PERIOD_W-1:0] : w_trial[PERIOD_W-1:0];
                r_q   <= {r_q[PERIOD_W-2:0], w_ge};
                r_x   <= {r_x[PERIOD_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule
`default_nettype wire
